// ===== src/svpwm_pkg.sv =====
`timescale 1ns / 1ps

package svpwm_pkg;

	// default field widths
	localparam int VOLT_WIDTH = 16;
	localparam int DUTY_FRAC_BITS = 15;
	localparam int DUTY_W = 16;
	localparam int SECTOR_W = 3;

	// sqrt(3) in Q16
	localparam int SQRT3_W = 17;
	localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;

	// active time = w * sqrt3 * 2^F / (bus * 2^33)
	localparam int TIME_SCALE_LOG2 = 33;
	// overmodulation operands are shifted down below this power of two
	localparam int NORM_LIMIT_LOG2 = 38;

	localparam logic [SECTOR_W-1:0] SEC_NONE = 3'd0;
	localparam logic [SECTOR_W-1:0] SEC_1 = 3'd1;
	localparam logic [SECTOR_W-1:0] SEC_2 = 3'd2;
	localparam logic [SECTOR_W-1:0] SEC_3 = 3'd3;
	localparam logic [SECTOR_W-1:0] SEC_4 = 3'd4;
	localparam logic [SECTOR_W-1:0] SEC_5 = 3'd5;
	localparam logic [SECTOR_W-1:0] SEC_6 = 3'd6;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// sign pattern {w3 > 0, w2 > 0, w1 > 0} to sector
	function automatic logic [SECTOR_W-1:0] sector_of(input logic [2:0] code);
		logic [SECTOR_W-1:0] s;
		case (code)
			3'b001: s = SEC_2;
			3'b010: s = SEC_6;
			3'b011: s = SEC_1;
			3'b100: s = SEC_4;
			3'b101: s = SEC_3;
			3'b110: s = SEC_5;
			default: s = SEC_NONE;
		endcase
		return s;
	endfunction

endpackage

// ===== src/svpwm_in_if.sv =====
`timescale 1ns / 1ps

interface svpwm_in_if #(
	parameter int VOLT_WIDTH = svpwm_pkg::VOLT_WIDTH
);
	logic valid;
	logic ready;
	logic signed [VOLT_WIDTH-1:0] volt_alpha;
	logic signed [VOLT_WIDTH-1:0] volt_beta;
	logic [VOLT_WIDTH-1:0] bus_voltage;

	modport source(output valid, output volt_alpha, output volt_beta, output bus_voltage,
		input ready);
	modport sink(input valid, input volt_alpha, input volt_beta, input bus_voltage,
		output ready);
endinterface

// ===== src/svpwm_out_if.sv =====
`timescale 1ns / 1ps

interface svpwm_out_if;
	logic valid;
	logic ready;
	logic [svpwm_pkg::DUTY_W-1:0] duty_a;
	logic [svpwm_pkg::DUTY_W-1:0] duty_b;
	logic [svpwm_pkg::DUTY_W-1:0] duty_c;
	logic [svpwm_pkg::SECTOR_W-1:0] sector;
	logic valid_res;

	modport source(output valid, output duty_a, output duty_b, output duty_c,
		output sector, output valid_res, input ready);
	modport sink(input valid, input duty_a, input duty_b, input duty_c,
		input sector, input valid_res, output ready);
endinterface

// ===== src/svpwm_div_lane.sv =====
`timescale 1ns / 1ps

// radix-2 restoring divider lane, one quotient bit per step
module svpwm_div_lane #(
	parameter int DVW = 8,
	parameter int QW = 4
) (
	input logic clk,
	input svpwm_pkg::div_ctrl_t ctrl,
	input logic [DVW-1:0] init_rem,
	input logic [QW-1:0] init_low,
	input logic [DVW-1:0] divisor,
	output logic [QW-1:0] quot
);

	logic [DVW-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [QW-1:0] quot_q;
	logic [DVW:0] trial;
	logic [DVW+1:0] diff;
	logic take;

	assign trial = {rem_q, low_q[QW-1]};
	assign diff = {1'b0, trial} - {2'b00, divisor};
	assign take = !diff[DVW+1];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= init_rem;
			low_q <= init_low;
			quot_q <= '0;
		end else if (ctrl.step) begin
			rem_q <= take ? diff[DVW-1:0] : trial[DVW-1:0];
			low_q <= low_q << 1;
			quot_q <= {quot_q[QW-2:0], take};
		end
	end

	assign quot = quot_q;

endmodule

// ===== src/svpwm_duty_calc_unit.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                                   | transfer when
// cmd     | in  | volt_alpha, volt_beta, bus_voltage        | cmd.valid & cmd.ready
// res     | out | duty_a, duty_b, duty_c, sector, valid_res | res.valid & res.ready
//
// one command at a time; cmd.ready is high only while idle
// active sector: selection, the 17-step bit-serial sqrt3 multiply, the F+2-step
// active time division, the time state and the finish state
// overmodulation adds the normalizing shifts and the ratio division
// zero vector: selection then finish; a full output register stalls the finish state
// reset clears the controller, output register and held duties (held flag set)

module svpwm_duty_calc_unit #(
	parameter int VOLT_WIDTH = svpwm_pkg::VOLT_WIDTH,
	parameter int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	svpwm_in_if.sink cmd,
	svpwm_out_if.source res
);

	// projection widths: |w| < 2^(V+17)
	localparam int WW = VOLT_WIDTH + 18;
	localparam int MAGW = VOLT_WIDTH + 17;
	localparam int SW = svpwm_pkg::SQRT3_W;
	localparam int SIW = $clog2(SW);
	// product w * sqrt3 and its split for the active time division
	localparam int NW = MAGW + SW;
	localparam int QW = DUTY_FRAC_BITS + 2;
	localparam int HW = NW - QW;
	localparam int TIME_SHIFT = svpwm_pkg::TIME_SCALE_LOG2 - DUTY_FRAC_BITS;
	localparam int DW = VOLT_WIDTH + TIME_SHIFT;
	localparam int SUMW = MAGW + 1;
	localparam int DVW = (DW > SUMW) ? DW : SUMW;
	localparam int EXTW = SUMW + svpwm_pkg::NORM_LIMIT_LOG2 + 1;
	// time, held duty and signed duty widths
	localparam int TW = DUTY_FRAC_BITS + 3;
	localparam int HDW = DUTY_FRAC_BITS + 1;
	localparam int DSW = DUTY_FRAC_BITS + 6;
	localparam int CNTMAX = ((SW > QW) ? SW : QW) - 1;
	localparam int CNTW = $clog2(CNTMAX + 1);

	localparam logic [TW-1:0] ONE = TW'(1) << DUTY_FRAC_BITS;
	localparam logic [TW-1:0] CAP = TW'(1) << (DUTY_FRAC_BITS + 2);
	localparam logic [HDW-1:0] ONE_H = HDW'(1) << DUTY_FRAC_BITS;
	localparam logic signed [DSW-1:0] ONE_S = $signed(DSW'(1) << DUTY_FRAC_BITS);
	localparam logic signed [SW:0] S_SGN = {1'b0, svpwm_pkg::SQRT3_Q16};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL,
		ST_MUL,
		ST_LDA,
		ST_DIVA,
		ST_TIME,
		ST_NORM,
		ST_DIVB,
		ST_OVR,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [CNTW-1:0] cnt_q;

	// datapath registers
	logic signed [WW-1:0] w1_q, w2_q, w3_q;
	logic [VOLT_WIDTH-1:0] bus_q;
	logic [svpwm_pkg::SECTOR_W-1:0] sector_q;
	logic [MAGW-1:0] ux_q, uy_q;
	logic [NW-1:0] acc_x_q, acc_y_q;
	logic sat_x_q, sat_y_q, zero_x_q, zero_y_q;
	logic [DVW-1:0] div_d_q;
	logic [TW-1:0] tx_q, ty_q;

	// held duties and output register
	logic [HDW-1:0] held_a_q, held_b_q, held_c_q;
	logic held_ok_q;
	logic res_valid_q;
	logic [svpwm_pkg::DUTY_W-1:0] duty_a_q, duty_b_q, duty_c_q;
	logic [svpwm_pkg::SECTOR_W-1:0] sector_out_q;
	logic valid_res_q;

	// projections of the command, formed on the transfer
	logic signed [WW-1:0] sa;
	logic signed [WW-1:0] beta_ext;
	logic signed [WW-1:0] w1_in, w2_in, w3_in;

	assign sa = S_SGN * cmd.volt_alpha;
	assign beta_ext = WW'(cmd.volt_beta);
	assign w1_in = beta_ext <<< 17;
	assign w2_in = sa - (beta_ext <<< 16);
	assign w3_in = -sa - (beta_ext <<< 16);

	// sector and the two active projections
	logic [svpwm_pkg::SECTOR_W-1:0] sect;
	logic signed [WW-1:0] wx, wy;
	logic [MAGW-1:0] ux_new, uy_new;

	assign sect = svpwm_pkg::sector_of({w3_q > 0, w2_q > 0, w1_q > 0});

	always_comb begin
		case (sect)
			svpwm_pkg::SEC_1: begin
				wx = w2_q;
				wy = w1_q;
			end
			svpwm_pkg::SEC_2: begin
				wx = -w2_q;
				wy = -w3_q;
			end
			svpwm_pkg::SEC_3: begin
				wx = w1_q;
				wy = w3_q;
			end
			svpwm_pkg::SEC_4: begin
				wx = -w1_q;
				wy = -w2_q;
			end
			svpwm_pkg::SEC_5: begin
				wx = w3_q;
				wy = w2_q;
			end
			default: begin
				wx = -w3_q;
				wy = -w1_q;
			end
		endcase
	end

	assign ux_new = (wx > 0) ? wx[MAGW-1:0] : '0;
	assign uy_new = (wy > 0) ? wy[MAGW-1:0] : '0;

	// bit-serial multiply by sqrt3, msb first
	logic s_bit;
	assign s_bit = svpwm_pkg::SQRT3_Q16[cnt_q[SIW-1:0]];

	// active time division: high part vs. bus scaled to the time lsb
	logic [DVW-1:0] d_bus;
	logic [DVW-1:0] h_x, h_y;
	assign d_bus = DVW'({bus_q, {TIME_SHIFT{1'b0}}});
	assign h_x = DVW'(acc_x_q[NW-1:QW]);
	assign h_y = DVW'(acc_y_q[NW-1:QW]);

	// overmodulation normalization
	logic [EXTW-1:0] sum_ext;
	logic norm_more;
	assign sum_ext = EXTW'(ux_q) + EXTW'(uy_q);
	assign norm_more = (sum_ext >> svpwm_pkg::NORM_LIMIT_LOG2) != '0;

	// divider lanes, shared by the active time and the ratio division
	svpwm_pkg::div_ctrl_t div_ctrl;
	logic [DVW-1:0] init_rem_x, init_rem_y;
	logic [QW-1:0] init_low_x, init_low_y;
	logic [QW-1:0] quot_x, quot_y;

	always_comb begin
		div_ctrl.load = (state_q == ST_LDA) || (state_q == ST_NORM && !norm_more);
		div_ctrl.step = (state_q == ST_DIVA) || (state_q == ST_DIVB);
		if (state_q == ST_LDA) begin
			init_rem_x = h_x;
			init_rem_y = h_y;
			init_low_x = acc_x_q[QW-1:0];
			init_low_y = acc_y_q[QW-1:0];
		end else begin
			// ux * 2^F over ux + uy, F+1 quotient bits
			init_rem_x = DVW'(ux_q >> 1);
			init_rem_y = DVW'(uy_q >> 1);
			init_low_x = {ux_q[0], {(QW-1){1'b0}}};
			init_low_y = {uy_q[0], {(QW-1){1'b0}}};
		end
	end

	svpwm_div_lane #(.DVW(DVW), .QW(QW)) u_div_x (
		.clk(clk),
		.ctrl(div_ctrl),
		.init_rem(init_rem_x),
		.init_low(init_low_x),
		.divisor(div_d_q),
		.quot(quot_x)
	);

	svpwm_div_lane #(.DVW(DVW), .QW(QW)) u_div_y (
		.clk(clk),
		.ctrl(div_ctrl),
		.init_rem(init_rem_y),
		.init_low(init_low_y),
		.divisor(div_d_q),
		.quot(quot_y)
	);

	// active times, saturated at four periods
	logic [TW-1:0] tx_new, ty_new;
	logic ovr;
	assign tx_new = zero_x_q ? '0 : (sat_x_q ? CAP : TW'(quot_x));
	assign ty_new = zero_y_q ? '0 : (sat_y_q ? CAP : TW'(quot_y));
	assign ovr = ((TW+1)'(tx_new) + (TW+1)'(ty_new)) > (TW+1)'(ONE);

	// centered duties, floor of the quarter sums
	logic signed [DSW-1:0] ta4, tb4, tc4, ta, tb, tc;
	logic ok_new;
	logic [HDW-1:0] da, db, dc;
	logic [HDW-1:0] na, nb, nc;

	function automatic logic [HDW-1:0] clamp_duty(input logic signed [DSW-1:0] v);
		logic [HDW-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > ONE_S)
			r = ONE_H;
		else
			r = v[HDW-1:0];
		return r;
	endfunction

	assign ta4 = $signed(DSW'(ONE)) + $signed(DSW'(tx_q)) + $signed(DSW'(ty_q));
	assign tb4 = ta4 - $signed(DSW'(tx_q) << 1);
	assign tc4 = tb4 - $signed(DSW'(ty_q) << 1);
	assign ta = ta4 >>> 2;
	assign tb = tb4 >>> 2;
	assign tc = tc4 >>> 2;
	assign ok_new = !ta[DSW-1] && ta <= ONE_S && !tb[DSW-1] && tb <= ONE_S &&
		!tc[DSW-1] && tc <= ONE_S;
	assign da = clamp_duty(ta);
	assign db = clamp_duty(tb);
	assign dc = clamp_duty(tc);

	// route to phases by sector
	always_comb begin
		case (sector_q)
			svpwm_pkg::SEC_1: begin
				na = da;
				nb = db;
				nc = dc;
			end
			svpwm_pkg::SEC_2: begin
				na = db;
				nb = da;
				nc = dc;
			end
			svpwm_pkg::SEC_3: begin
				na = dc;
				nb = da;
				nc = db;
			end
			svpwm_pkg::SEC_4: begin
				na = dc;
				nb = db;
				nc = da;
			end
			svpwm_pkg::SEC_5: begin
				na = db;
				nb = dc;
				nc = da;
			end
			default: begin
				na = da;
				nb = dc;
				nc = db;
			end
		endcase
	end

	logic active;
	logic fin_go;
	logic [HDW-1:0] oa, ob, oc;
	logic ok_out;
	assign active = sector_q != svpwm_pkg::SEC_NONE;
	assign fin_go = !res_valid_q || res.ready;
	assign oa = active ? na : held_a_q;
	assign ob = active ? nb : held_b_q;
	assign oc = active ? nc : held_c_q;
	// zero vector re-checks the held flag against the new bus sample
	assign ok_out = (active ? ok_new : held_ok_q) && (bus_q != '0);

	assign cmd.ready = (state_q == ST_IDLE);

	// controller, held duties and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			held_a_q <= '0;
			held_b_q <= '0;
			held_c_q <= '0;
			held_ok_q <= 1'b1;
			res_valid_q <= 1'b0;
			duty_a_q <= '0;
			duty_b_q <= '0;
			duty_c_q <= '0;
			sector_out_q <= svpwm_pkg::SEC_NONE;
			valid_res_q <= 1'b0;
		end else begin
			// in the finish state a drained output register is refilled below
			if (res_valid_q && res.ready && state_q != ST_FIN)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid)
						state_q <= ST_SEL;
				end
				ST_SEL: begin
					cnt_q <= CNTW'(SW - 1);
					state_q <= (sect == svpwm_pkg::SEC_NONE) ? ST_FIN : ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_LDA;
				end
				ST_LDA: begin
					cnt_q <= CNTW'(QW - 1);
					state_q <= ST_DIVA;
				end
				ST_DIVA: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_TIME;
				end
				ST_TIME: begin
					state_q <= ovr ? ST_NORM : ST_FIN;
				end
				ST_NORM: begin
					if (!norm_more) begin
						cnt_q <= CNTW'(HDW - 1);
						state_q <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_OVR;
				end
				ST_OVR: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						if (active) begin
							held_a_q <= na;
							held_b_q <= nb;
							held_c_q <= nc;
							held_ok_q <= ok_new;
						end
						duty_a_q <= svpwm_pkg::DUTY_W'(oa);
						duty_b_q <= svpwm_pkg::DUTY_W'(ob);
						duty_c_q <= svpwm_pkg::DUTY_W'(oc);
						sector_out_q <= sector_q;
						valid_res_q <= ok_out;
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					w1_q <= w1_in;
					w2_q <= w2_in;
					w3_q <= w3_in;
					bus_q <= cmd.bus_voltage;
				end
			end
			ST_SEL: begin
				sector_q <= sect;
				ux_q <= ux_new;
				uy_q <= uy_new;
				acc_x_q <= '0;
				acc_y_q <= '0;
			end
			ST_MUL: begin
				acc_x_q <= (acc_x_q << 1) + (s_bit ? NW'(ux_q) : '0);
				acc_y_q <= (acc_y_q << 1) + (s_bit ? NW'(uy_q) : '0);
			end
			ST_LDA: begin
				// quotient would reach four periods: saturate
				sat_x_q <= h_x >= d_bus;
				sat_y_q <= h_y >= d_bus;
				zero_x_q <= ux_q == '0;
				zero_y_q <= uy_q == '0;
				div_d_q <= d_bus;
			end
			ST_TIME: begin
				tx_q <= tx_new;
				ty_q <= ty_new;
			end
			ST_NORM: begin
				if (norm_more) begin
					ux_q <= ux_q >> 1;
					uy_q <= uy_q >> 1;
				end else begin
					div_d_q <= DVW'(sum_ext);
				end
			end
			ST_OVR: begin
				tx_q <= TW'(quot_x[HDW-1:0]);
				ty_q <= TW'(quot_y[HDW-1:0]);
			end
			default: begin
			end
		endcase
	end

	assign res.valid = res_valid_q;
	assign res.duty_a = duty_a_q;
	assign res.duty_b = duty_b_q;
	assign res.duty_c = duty_c_q;
	assign res.sector = sector_out_q;
	assign res.valid_res = valid_res_q;

`ifndef SYNTHESIS
	a_ovr_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OVR |=> ((TW+1)'(tx_q) + (TW+1)'(ty_q)) <= (TW+1)'(ONE))
		else $error("overmodulation times exceed one period");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_a_q <= ONE_H && held_b_q <= ONE_H && held_c_q <= ONE_H)
		else $error("held duty above full period");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && fin_go |=> res.valid && state_q == ST_IDLE)
		else $error("finished item did not reach the output register");

	a_zero_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && sector_q == svpwm_pkg::SEC_NONE |=>
		$stable(held_a_q) && $stable(held_b_q) && $stable(held_c_q))
		else $error("zero vector changed held duties");
`endif

endmodule

// ===== tb/svpwm_duty_calc_unit_tb.sv =====
`timescale 1ns / 1ps

module svpwm_duty_calc_unit_tb;

	// widths and scaling taken from the package
	localparam int VOLT_WIDTH = svpwm_pkg::VOLT_WIDTH;
	localparam int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS;
	localparam int DUTY_W = svpwm_pkg::DUTY_W;
	localparam int SECTOR_W = svpwm_pkg::SECTOR_W;

	// run length and pacing
	localparam int RANDOM_ITEMS = 500;
	localparam int CALM_ITEMS = 60;          // tail of the run with no idling
	localparam int DRAIN_PAUSE_AT = 250;     // sender waits for every result here
	localparam int LONG_HOLD_AT = 150;       // receiver stalls after this many results
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 120;       // longer than the longest busy stretch
	localparam int CYCLE_LIMIT = 300000;

	// fixed-point constants of the duty math
	localparam longint DUTY_ONE = longint'(1) << DUTY_FRAC_BITS;
	localparam longint TIME_CAP = 4 * DUTY_ONE;
	localparam longint NORM_LIMIT = longint'(1) << svpwm_pkg::NORM_LIMIT_LOG2;
	localparam longint SQRT3 = longint'(svpwm_pkg::SQRT3_Q16);
	localparam int TIME_SHIFT = svpwm_pkg::TIME_SCALE_LOG2 - DUTY_FRAC_BITS;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
		logic [DUTY_W-1:0] duty_c;
		logic [SECTOR_W-1:0] sector;
		logic valid_res;
	} duty_res_t;

	// one command; typed rows carry a hand-written expected result
	typedef struct packed {
		logic signed [VOLT_WIDTH-1:0] alpha;
		logic signed [VOLT_WIDTH-1:0] beta;
		logic [VOLT_WIDTH-1:0] bus;
		logic typed;
		duty_res_t want;
	} cmd_row_t;

	logic clk;
	logic arst_n;

	svpwm_in_if cmd();
	svpwm_out_if res();

	svpwm_duty_calc_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res)
	);

	// predictor state: duties held across zero-vector commands
	logic [DUTY_W-1:0] held_a = '0;
	logic [DUTY_W-1:0] held_b = '0;
	logic [DUTY_W-1:0] held_c = '0;
	bit held_ok = 1'b1;

	duty_res_t pending_duties[$];
	cmd_row_t plan[$];
	int fail_count = 0;
	int duties_seen = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	bit calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("svpwm_duty_calc_unit_tb: FAIL");
		$finish;
	end

	// active vector time: floor(w * sqrt3 * 2^F / (bus * 2^33)), capped at four periods
	function automatic longint active_time_of(input longint w, input longint bus);
		longint q, rm, v;
		if (w == 0)
			return 0;
		if (bus == 0)
			return TIME_CAP;
		q = w / bus;
		rm = w % bus;
		if (q >= (longint'(1) << 40))
			return TIME_CAP;
		v = (q * SQRT3 + (rm * SQRT3) / bus) >> TIME_SHIFT;
		return (v > TIME_CAP) ? TIME_CAP : v;
	endfunction

	function automatic logic [DUTY_W-1:0] clamp_duty(input longint v);
		if (v < 0)
			return '0;
		if (v > DUTY_ONE)
			return DUTY_W'(DUTY_ONE);
		return DUTY_W'(v);
	endfunction

	// works out the result of one command and updates the held duties
	function automatic duty_res_t predict_duties(input cmd_row_t c);
		longint a, b, bus, sa, w1, w2, w3, wx, wy, tx, ty, sum, ta, tb, tc;
		logic [2:0] signs;
		duty_res_t r;
		bit raw_ok;
		a = longint'($signed(c.alpha));
		b = longint'($signed(c.beta));
		bus = longint'(c.bus);
		// projections scaled by 2^17
		sa = SQRT3 * a;
		w1 = b * 131072;
		w2 = sa - b * 65536;
		w3 = -sa - b * 65536;
		signs = {w3 > 0, w2 > 0, w1 > 0};
		case (signs)
			3'b001: r.sector = svpwm_pkg::SEC_2;
			3'b010: r.sector = svpwm_pkg::SEC_6;
			3'b011: r.sector = svpwm_pkg::SEC_1;
			3'b100: r.sector = svpwm_pkg::SEC_4;
			3'b101: r.sector = svpwm_pkg::SEC_3;
			3'b110: r.sector = svpwm_pkg::SEC_5;
			default: r.sector = svpwm_pkg::SEC_NONE;
		endcase
		if (r.sector != svpwm_pkg::SEC_NONE) begin
			case (r.sector)
				svpwm_pkg::SEC_1: begin wx = w2; wy = w1; end
				svpwm_pkg::SEC_2: begin wx = -w2; wy = -w3; end
				svpwm_pkg::SEC_3: begin wx = w1; wy = w3; end
				svpwm_pkg::SEC_4: begin wx = -w1; wy = -w2; end
				svpwm_pkg::SEC_5: begin wx = w3; wy = w2; end
				default: begin wx = -w3; wy = -w1; end
			endcase
			if (wx < 0)
				wx = 0;
			if (wy < 0)
				wy = 0;
			tx = active_time_of(wx, bus);
			ty = active_time_of(wy, bus);
			// overmodulation: scale both times in proportion so they fit within one period
			if (tx + ty > DUTY_ONE) begin
				while (wx + wy >= NORM_LIMIT) begin
					wx = wx >> 1;
					wy = wy >> 1;
				end
				sum = wx + wy;
				if (sum == 0) begin
					tx = 0;
					ty = 0;
				end else begin
					tx = (wx * DUTY_ONE) / sum;
					ty = (wy * DUTY_ONE) / sum;
				end
			end
			// centered duties, floor of the quarter sums
			ta = (DUTY_ONE + tx + ty) >>> 2;
			tb = (DUTY_ONE - tx + ty) >>> 2;
			tc = (DUTY_ONE - tx - ty) >>> 2;
			raw_ok = ta >= 0 && ta <= DUTY_ONE && tb >= 0 && tb <= DUTY_ONE &&
				tc >= 0 && tc <= DUTY_ONE;
			case (r.sector)
				svpwm_pkg::SEC_1: begin
					held_a = clamp_duty(ta);
					held_b = clamp_duty(tb);
					held_c = clamp_duty(tc);
				end
				svpwm_pkg::SEC_2: begin
					held_a = clamp_duty(tb);
					held_b = clamp_duty(ta);
					held_c = clamp_duty(tc);
				end
				svpwm_pkg::SEC_3: begin
					held_a = clamp_duty(tc);
					held_b = clamp_duty(ta);
					held_c = clamp_duty(tb);
				end
				svpwm_pkg::SEC_4: begin
					held_a = clamp_duty(tc);
					held_b = clamp_duty(tb);
					held_c = clamp_duty(ta);
				end
				svpwm_pkg::SEC_5: begin
					held_a = clamp_duty(tb);
					held_b = clamp_duty(tc);
					held_c = clamp_duty(ta);
				end
				default: begin
					held_a = clamp_duty(ta);
					held_b = clamp_duty(tc);
					held_c = clamp_duty(tb);
				end
			endcase
			held_ok = raw_ok;
		end
		r.duty_a = held_a;
		r.duty_b = held_b;
		r.duty_c = held_c;
		r.valid_res = held_ok && (bus != 0);
		return r;
	endfunction

	function automatic cmd_row_t plan_row(input int alpha, input int beta, input int bus,
		input bit typed, input int da, input int db, input int dc,
		input logic [SECTOR_W-1:0] sec, input bit ok);
		cmd_row_t r;
		r.alpha = VOLT_WIDTH'(alpha);
		r.beta = VOLT_WIDTH'(beta);
		r.bus = VOLT_WIDTH'(bus);
		r.typed = typed;
		r.want.duty_a = DUTY_W'(da);
		r.want.duty_b = DUTY_W'(db);
		r.want.duty_c = DUTY_W'(dc);
		r.want.sector = sec;
		r.want.valid_res = ok;
		return r;
	endfunction

	// mix of zero vectors, dead bus, small commands, heavy overmodulation,
	// sector edges, realistic operating points and raw full-range noise
	function automatic cmd_row_t random_row();
		int mode, a, b, bus;
		mode = $urandom_range(0, 9);
		a = $urandom;
		b = $urandom;
		bus = $urandom;
		case (mode)
			0: begin
				a = 0;
				b = 0;
				if ($urandom_range(0, 3) == 0)
					bus = 0;
			end
			1: bus = 0;
			2: begin
				a = $urandom_range(0, 400) - 200;
				b = $urandom_range(0, 400) - 200;
			end
			3: bus = $urandom_range(1, 300);
			4: begin
				if ($urandom_range(0, 1) == 1)
					b = 0;
				else
					a = 0;
			end
			5, 6: begin
				bus = $urandom_range(2000, 65535);
				a = $urandom_range(0, bus) - bus / 2;
				b = $urandom_range(0, bus) - bus / 2;
			end
			default: ;
		endcase
		return plan_row(a, b, bus, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0);
	endfunction

	// offer one command and hold it until the transfer; the result is queued then
	task automatic offer_cmd(input cmd_row_t row);
		duty_res_t model;
		cmd.valid <= 1'b1;
		cmd.volt_alpha <= row.alpha;
		cmd.volt_beta <= row.beta;
		cmd.bus_voltage <= row.bus;
		@(posedge clk);
		while (cmd.ready !== 1'b1)
			@(posedge clk);
		model = predict_duties(row);
		pending_duties.push_back(row.typed ? row.want : model);
	endtask

	// random burst of idle cycles on the command side
	task automatic idle_cmd_side();
		if (idle_on && !calm && $urandom_range(0, 2) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 11))
				@(posedge clk);
		end
	endtask

	task automatic check_field(input string what, input logic [DUTY_W-1:0] want,
		input logic [DUTY_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// result side: checks every transfer, stalls in bursts and once for a long stretch
	initial begin
		int ready_wait;
		bit long_done;
		duty_res_t want;
		ready_wait = 0;
		long_done = 1'b0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				duties_seen++;
				if (pending_duties.size() == 0) begin
					fail_count++;
					$display("%0t: result transfer with no command pending, sector %0d",
						$time, res.sector);
				end else begin
					want = pending_duties.pop_front();
					check_field("duty_a", want.duty_a, res.duty_a);
					check_field("duty_b", want.duty_b, res.duty_b);
					check_field("duty_c", want.duty_c, res.duty_c);
					check_field("sector", DUTY_W'(want.sector), DUTY_W'(res.sector));
					check_field("valid_res", DUTY_W'(want.valid_res),
						DUTY_W'(res.valid_res));
				end
			end
			// long hold-off: the block fills up and must stall its command side
			if (!long_done && duties_seen == LONG_HOLD_AT) begin
				ready_wait = LONG_HOLD_CYCLES;
				long_done = 1'b1;
			end
			if (ready_wait > 0) begin
				res.ready <= 1'b0;
				ready_wait--;
			end else begin
				res.ready <= 1'b1;
				if (idle_on && !calm && $urandom_range(0, 3) == 0)
					ready_wait = $urandom_range(1, 11);
			end
		end
	end

	// command side and end of run
	initial begin
		arst_n = 1'b0;
		cmd.valid <= 1'b0;
		cmd.volt_alpha <= '0;
		cmd.volt_beta <= '0;
		cmd.bus_voltage <= '0;

		// directed rows; typed results follow straight from reset values and extremes
		// zero vector right after reset: zero duties, held flag still set
		plan.push_back(plan_row(0, 0, 1000, 1'b1, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b1));
		// zero vector on a dead bus
		plan.push_back(plan_row(0, 0, 0, 1'b1, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		// tiny command on the largest bus: no active time, all phases at a quarter
		plan.push_back(plan_row(1, 0, 65535, 1'b1, 8192, 8192, 8192, svpwm_pkg::SEC_6, 1'b1));
		// dead bus saturates the time and forces overmodulation onto one vector
		plan.push_back(plan_row(1, 0, 0, 1'b1, 16384, 0, 0, svpwm_pkg::SEC_6, 1'b0));
		// zero vector holds those duties, now with a live bus
		plan.push_back(plan_row(0, 0, 100, 1'b1, 16384, 0, 0, svpwm_pkg::SEC_NONE, 1'b1));
		plan.push_back(plan_row(-1, 0, 65535, 1'b1, 8192, 8192, 8192, svpwm_pkg::SEC_4, 1'b1));
		// one command per sector
		plan.push_back(plan_row(1000, 500, 20000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(0, 1000, 20000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(-1000, 500, 20000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(-1000, -500, 20000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(0, -1000, 20000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(1000, -500, 20000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		// overmodulation and field extremes
		plan.push_back(plan_row(20000, 10000, 1000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(32767, 32767, 1, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(-32768, -32768, 1, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(-32768, 32767, 65535, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE,
			1'b0));
		plan.push_back(plan_row(32767, -32768, 65535, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE,
			1'b0));
		plan.push_back(plan_row(32767, 0, 0, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(0, -32768, 0, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(-1, -1, 65535, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(0, 0, 65535, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(12000, -7000, 30000, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));
		plan.push_back(plan_row(0, 0, 0, 1'b0, 0, 0, 0, svpwm_pkg::SEC_NONE, 1'b0));

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			offer_cmd(plan[i]);
			idle_cmd_side();
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// idling switches on and off in stretches
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (n >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			// sender pause until the block has handed back everything
			if (n == DRAIN_PAUSE_AT) begin
				cmd.valid <= 1'b0;
				while (pending_duties.size() != 0)
					@(posedge clk);
			end
			offer_cmd(random_row());
			idle_cmd_side();
		end

		cmd.valid <= 1'b0;
		while (pending_duties.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one expected
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("svpwm_duty_calc_unit_tb: PASS");
		else
			$display("svpwm_duty_calc_unit_tb: FAIL");
		$finish;
	end

endmodule
